// File: src/point_mass_drag_integrator_macros.svh
// assertion macros for the point mass integrator
`ifndef POINT_MASS_DRAG_INTEGRATOR_MACROS_SVH
`define POINT_MASS_DRAG_INTEGRATOR_MACROS_SVH
`ifndef SYNTHESIS
`define PMDI_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("pmdi assertion failed");
`define PMDI_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pmdi implication failed");
`else
`define PMDI_ASSERT(lbl, clk, rst, prop)
`define PMDI_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`endif
`endif

// File: src/pmdi_pkg.sv
`timescale 1ns / 1ps
package pmdi_pkg;

   localparam logic [1:0] MODE_STEP = 2'd0;
   localparam logic [1:0] MODE_POS  = 2'd1;
   localparam logic [1:0] MODE_VEL  = 2'd2;
   localparam logic [1:0] MODE_NONE = 2'd3;

   localparam logic [2:0] CSR_ENABLED   = 3'd0;
   localparam logic [2:0] CSR_MASS      = 3'd1;
   localparam logic [2:0] CSR_DRAG_CON  = 3'd2;
   localparam logic [2:0] CSR_DRAG_MUL  = 3'd3;
   localparam logic [2:0] CSR_GRAVITY   = 3'd4;

   localparam logic [1:0] AX_LAST = 2'd2;

   localparam logic [30:0] MASS_RESET    = 31'd65536;
   localparam logic [30:0] DRAG_MUL_RESET = 31'd65536;
   localparam logic [30:0] GRAVITY_RESET = 31'd642253;

   typedef enum logic [12:0] {
      ST_IDLE   = 13'b0000000000001,
      ST_SQUARE = 13'b0000000000010,
      ST_ROOT   = 13'b0000000000100,
      ST_DRAG_T = 13'b0000000001000,
      ST_DRAG_S = 13'b0000000010000,
      ST_WEIGHT = 13'b0000000100000,
      ST_DT_SQ  = 13'b0000001000000,
      ST_FORCE  = 13'b0000010000000,
      ST_DIVIDE = 13'b0000100000000,
      ST_VEL_T  = 13'b0001000000000,
      ST_HALF   = 13'b0010000000000,
      ST_VEL_D  = 13'b0100000000000,
      ST_RESP   = 13'b1000000000000
   } state_type;

   typedef struct packed {
      logic start;
      logic shift17;
   } mul_ctl_type;

   typedef struct packed {
      logic start;
      logic is_root;
      logic neg;
   } iter_ctl_type;

endpackage

// File: src/pmdi_mul.sv
`timescale 1ns / 1ps
module pmdi_mul #(
   parameter int WORD_BITS = 32,
   parameter int MUL_BITS  = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  pmdi_pkg::mul_ctl_type          ctl,
   input  logic signed [MUL_BITS-1:0]     op_a,
   input  logic signed [MUL_BITS-1:0]     op_b,
   output logic                           done,
   output logic [2*MUL_BITS-1:0]          prod,
   output logic signed [WORD_BITS-1:0]    res
);
   import pmdi_pkg::*;

   localparam int W  = WORD_BITS;
   localparam int MW = MUL_BITS;
   localparam int PW = 2 * MW;
   localparam int CW = $clog2(MW);
   localparam logic [PW:0] RND16 = {{(PW-15){1'b0}}, 1'b1, 15'b0};
   localparam logic [PW:0] RND17 = {{(PW-16){1'b0}}, 1'b1, 16'b0};

   logic [MW-1:0] a_ff, a_in, hi_ff, hi_in, lo_ff, lo_in;
   logic          neg_ff, neg_in, sh17_ff, sh17_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in, fin_ff, fin_in, done_ff, done_in;
   logic signed [W-1:0] res_ff, res_in;

   logic [MW-1:0] mag_a, mag_b;
   logic [MW:0]   part;
   logic [PW:0]   rnd, qv;
   logic [W-1:0]  lim, mv;

   always_comb begin
      mag_a = op_a[MW-1] ? (~op_a + 1'b1) : op_a;
      mag_b = op_b[MW-1] ? (~op_b + 1'b1) : op_b;
      // one multiplier bit per cycle, product shifts in from the top
      part  = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, a_ff} : {(MW+1){1'b0}});
      rnd   = {1'b0, hi_ff, lo_ff} + (sh17_ff ? RND17 : RND16);
      qv    = sh17_ff ? (rnd >> 17) : (rnd >> 16);
      lim   = neg_ff ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      mv    = (qv > {{(PW+1-W){1'b0}}, lim}) ? lim : qv[W-1:0];
   end

   always_comb begin
      a_in    = a_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      neg_in  = neg_ff;
      sh17_in = sh17_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      fin_in  = 1'b0;
      done_in = 1'b0;
      res_in  = res_ff;
      if (ctl.start) begin
         a_in    = mag_a;
         lo_in   = mag_b;
         hi_in   = '0;
         neg_in  = op_a[MW-1] ^ op_b[MW-1];
         sh17_in = ctl.shift17;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         hi_in  = part[MW:1];
         lo_in  = {part[0], lo_ff[MW-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(MW-1)) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end else if (fin_ff) begin
         res_in  = neg_ff ? (~mv + 1'b1) : mv;
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      hi_ff   <= hi_in;
      lo_ff   <= lo_in;
      neg_ff  <= neg_in;
      sh17_ff <= sh17_in;
      cnt_ff  <= cnt_in;
      res_ff  <= res_in;
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign prod = {hi_ff, lo_ff};
   assign res  = res_ff;

endmodule

// File: src/pmdi_iter.sv
`timescale 1ns / 1ps
module pmdi_iter #(
   parameter int WORD_BITS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  pmdi_pkg::iter_ctl_type      ctl,
   input  logic [2*WORD_BITS-1:0]      x_val,
   input  logic [30:0]                 divisor,
   output logic                        done,
   output logic signed [WORD_BITS-1:0] res
);
   import pmdi_pkg::*;

   localparam int W  = WORD_BITS;
   localparam int XW = 2 * W;
   localparam int QW = W + 17;
   localparam int RW = (W + 3 > 32) ? W + 3 : 32;
   localparam int CW = $clog2(W + 17);

   logic [XW-1:0] x_ff, x_in;
   logic [RW-1:0] rem_ff, rem_in;
   logic [QW-1:0] q_ff, q_in;
   logic [30:0]   d_ff, d_in;
   logic          root_ff, root_in, neg_ff, neg_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in, fin_ff, fin_in, done_ff, done_in;
   logic signed [W-1:0] res_ff, res_in;

   logic [RW-1:0] shv, trial;
   logic [QW+1:0] tq;
   logic          ge, last;
   logic [W-1:0]  lim, mv;

   always_comb begin
      // sqrt takes two radicand bits a step, division one
      shv   = root_ff ? {rem_ff[RW-3:0], x_ff[XW-1 -: 2]} : {rem_ff[RW-2:0], x_ff[XW-1]};
      tq    = {q_ff, 2'b01};
      trial = root_ff ? tq[RW-1:0] : {{(RW-31){1'b0}}, d_ff};
      ge    = shv >= trial;
      last  = cnt_ff == (root_ff ? CW'(W-1) : CW'(W+16));
      lim   = neg_ff ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      mv    = (q_ff > {{(QW-W){1'b0}}, lim}) ? lim : q_ff[W-1:0];
   end

   always_comb begin
      x_in    = x_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      d_in    = d_ff;
      root_in = root_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      fin_in  = 1'b0;
      done_in = 1'b0;
      res_in  = res_ff;
      if (ctl.start) begin
         x_in    = x_val;
         rem_in  = '0;
         q_in    = '0;
         d_in    = divisor;
         root_in = ctl.is_root;
         neg_in  = ctl.neg;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         x_in   = root_ff ? (x_ff << 2) : (x_ff << 1);
         rem_in = ge ? (shv - trial) : shv;
         q_in   = {q_ff[QW-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (last) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end else if (fin_ff) begin
         if (root_ff) begin
            res_in = q_ff[W-1] ? {1'b0, {(W-1){1'b1}}} : q_ff[W-1:0];
         end else begin
            res_in = neg_ff ? (~mv + 1'b1) : mv;
         end
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      rem_ff  <= rem_in;
      q_ff    <= q_in;
      d_ff    <= d_in;
      root_ff <= root_in;
      neg_ff  <= neg_in;
      cnt_ff  <= cnt_in;
      res_ff  <= res_in;
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign res  = res_ff;

endmodule

// File: src/point_mass_drag_integrator.sv
// step word: result loads in ST_RESP after the square, root, drag, weight, dt-squared, force,
// divide, velocity and half states; the next word is accepted once the state is back in ST_IDLE
// load, idle-mode and disabled words: go from ST_IDLE straight to ST_RESP and back to ST_IDLE
// step length is set by the bit-serial multiplier (one bit a cycle, 19 products a step) and the
// shared sqrt/divide unit (one result bit a cycle); a stalled result holds the next word
// synchronous active-high reset: state to ST_IDLE, control and CSR registers at their defaults, pos/vel/acc/force zero
`timescale 1ns / 1ps
`include "point_mass_drag_integrator_macros.svh"
module point_mass_drag_integrator #(
   parameter int WORD_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_mode,
   input  logic signed [31:0] req_vec_x,
   input  logic signed [31:0] req_vec_y,
   input  logic signed [31:0] req_vec_z,
   input  logic [15:0]        req_time_step,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic signed [31:0] rsp_pos_z,
   output logic signed [31:0] rsp_vel_x,
   output logic signed [31:0] rsp_vel_y,
   output logic signed [31:0] rsp_vel_z,
   output logic signed [31:0] rsp_acc_x,
   output logic signed [31:0] rsp_acc_y,
   output logic signed [31:0] rsp_acc_z,
   output logic signed [31:0] rsp_net_force_x,
   output logic signed [31:0] rsp_net_force_y,
   output logic signed [31:0] rsp_net_force_z,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [30:0]        csr_data
);
   import pmdi_pkg::*;

   localparam int W  = WORD_BITS;
   localparam int MW = (W > 32) ? W : 32;
   localparam longint W_MAX64 = (64'sd1 <<< (W - 1)) - 64'sd1;
   localparam longint W_MIN64 = -W_MAX64 - 64'sd1;
   localparam longint O_MAX64 = 64'sd2147483647;
   localparam longint O_MIN64 = -64'sd2147483648;

   function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
                                                   input logic signed [W-1:0] b);
      logic [W:0] s;
      s = {a[W-1], a} + {b[W-1], b};
      if (s[W] != s[W-1]) begin
         return s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end
      return s[W-1:0];
   endfunction

   function automatic logic signed [W-1:0] sat_sub(input logic signed [W-1:0] a,
                                                   input logic signed [W-1:0] b);
      logic [W:0] s;
      s = {a[W-1], a} - {b[W-1], b};
      if (s[W] != s[W-1]) begin
         return s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end
      return s[W-1:0];
   endfunction

   function automatic logic signed [W-1:0] in_word(input logic [31:0] raw);
      logic signed [63:0] e;
      e = 64'(signed'(raw));
      if (e > W_MAX64) begin
         e = W_MAX64;
      end else if (e < W_MIN64) begin
         e = W_MIN64;
      end
      return e[W-1:0];
   endfunction

   function automatic logic [31:0] out_word(input logic signed [W-1:0] v);
      logic signed [63:0] e;
      e = 64'(v);
      if (e > O_MAX64) begin
         e = O_MAX64;
      end else if (e < O_MIN64) begin
         e = O_MIN64;
      end
      return e[31:0];
   endfunction

   state_type state_ff, state_in;
   logic      issued_ff, issued_in;
   logic [1:0] ax_ff, ax_in;

   logic        en_ff, en_in;
   logic [30:0] mass_ff, mass_in, dcon_ff, dcon_in, dmul_ff, dmul_in, grav_ff, grav_in;

   logic signed [W-1:0] pos_ff [3];
   logic signed [W-1:0] pos_in [3];
   logic signed [W-1:0] vel_ff [3];
   logic signed [W-1:0] vel_in [3];
   logic signed [W-1:0] acc_ff [3];
   logic signed [W-1:0] acc_in [3];
   logic signed [W-1:0] frc_ff [3];
   logic signed [W-1:0] frc_in [3];
   logic signed [W-1:0] thr_ff [3];
   logic signed [W-1:0] thr_in [3];
   logic [15:0]         dt_ff, dt_in;
   logic [2*W-1:0]      sum_ff, sum_in;
   logic signed [W-1:0] spd_ff, spd_in, s_ff, s_in, wgt_ff, wgt_in;
   logic signed [W-1:0] dt2_ff, dt2_in, tmp_ff, tmp_in;

   logic [31:0] opos_ff [3];
   logic [31:0] opos_in [3];
   logic [31:0] ovel_ff [3];
   logic [31:0] ovel_in [3];
   logic [31:0] oacc_ff [3];
   logic [31:0] oacc_in [3];
   logic [31:0] ofrc_ff [3];
   logic [31:0] ofrc_in [3];
   logic        rsp_valid_ff, rsp_valid_in;

   mul_ctl_type         mul_ctl;
   iter_ctl_type        iter_ctl;
   logic signed [MW-1:0] op_a, op_b;
   logic                mul_done, iter_done;
   logic [2*MW-1:0]     mul_prod;
   logic signed [W-1:0] mul_res, iter_res;
   logic                mul_state, iter_state, rsp_free;
   logic signed [W-1:0] cur_vel, cur_frc, f_force;
   logic [W-1:0]        frc_mag;
   logic [30:0]         div_d;
   logic [W+16:0]       div_num;
   logic [2*W-1:0]      iter_x;

   assign cur_vel = vel_ff[ax_ff];
   assign cur_frc = frc_ff[ax_ff];
   assign mul_state = (state_ff == ST_SQUARE) || (state_ff == ST_DRAG_T) ||
                      (state_ff == ST_DRAG_S) || (state_ff == ST_WEIGHT) ||
                      (state_ff == ST_DT_SQ) || (state_ff == ST_FORCE) ||
                      (state_ff == ST_VEL_T) || (state_ff == ST_HALF) ||
                      (state_ff == ST_VEL_D);
   assign iter_state = (state_ff == ST_ROOT) || (state_ff == ST_DIVIDE);
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // zero mass counts as one ulp; numerator carries the rounding half
   assign div_d   = (mass_ff == '0) ? 31'd1 : mass_ff;
   assign frc_mag = cur_frc[W-1] ? (~cur_frc + 1'b1) : cur_frc;
   assign div_num = {1'b0, frc_mag, 16'b0} + {{(W-13){1'b0}}, div_d[30:1]};
   assign iter_x  = (state_ff == ST_ROOT) ? sum_ff : {div_num, {(W-17){1'b0}}};

   assign mul_ctl.start    = mul_state && !issued_ff;
   assign mul_ctl.shift17  = state_ff == ST_HALF;
   assign iter_ctl.start   = iter_state && !issued_ff;
   assign iter_ctl.is_root = state_ff == ST_ROOT;
   assign iter_ctl.neg     = cur_frc[W-1];

   always_comb begin
      op_a = '0;
      op_b = '0;
      unique case (state_ff)
         ST_SQUARE: begin
            op_a = MW'(cur_vel);
            op_b = MW'(cur_vel);
         end
         ST_DRAG_T: begin
            op_a = MW'(dcon_ff);
            op_b = MW'(spd_ff);
         end
         ST_DRAG_S: begin
            op_a = MW'(dmul_ff);
            op_b = MW'(tmp_ff);
         end
         ST_WEIGHT: begin
            op_a = MW'(grav_ff);
            op_b = MW'(mass_ff);
         end
         ST_DT_SQ: begin
            op_a = MW'(dt_ff);
            op_b = MW'(dt_ff);
         end
         ST_FORCE: begin
            op_a = MW'(s_ff);
            op_b = MW'(cur_vel);
         end
         ST_VEL_T: begin
            op_a = MW'(cur_vel);
            op_b = MW'(dt_ff);
         end
         ST_HALF: begin
            op_a = MW'(acc_ff[ax_ff]);
            op_b = MW'(dt2_ff);
         end
         ST_VEL_D: begin
            op_a = MW'(acc_ff[ax_ff]);
            op_b = MW'(dt_ff);
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   always_comb begin
      en_in   = en_ff;
      mass_in = mass_ff;
      dcon_in = dcon_ff;
      dmul_in = dmul_ff;
      grav_in = grav_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_ENABLED:  en_in   = csr_data[0];
            CSR_MASS:     mass_in = csr_data;
            CSR_DRAG_CON: dcon_in = csr_data;
            CSR_DRAG_MUL: dmul_in = csr_data;
            CSR_GRAVITY:  grav_in = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in  = state_ff;
      issued_in = issued_ff;
      ax_in     = ax_ff;
      pos_in    = pos_ff;
      vel_in    = vel_ff;
      acc_in    = acc_ff;
      frc_in    = frc_ff;
      thr_in    = thr_ff;
      dt_in     = dt_ff;
      sum_in    = sum_ff;
      spd_in    = spd_ff;
      s_in      = s_ff;
      wgt_in    = wgt_ff;
      dt2_in    = dt2_ff;
      tmp_in    = tmp_ff;
      opos_in   = opos_ff;
      ovel_in   = ovel_ff;
      oacc_in   = oacc_ff;
      ofrc_in   = ofrc_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      f_force   = (ax_ff == AX_LAST) ? sat_add(-wgt_ff, thr_ff[AX_LAST]) : thr_ff[ax_ff];

      if ((mul_state || iter_state) && !issued_ff) begin
         issued_in = 1'b1;
      end
      if (mul_done || iter_done) begin
         issued_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_mode)
                  MODE_POS: begin
                     pos_in[0] = in_word(req_vec_x);
                     pos_in[1] = in_word(req_vec_y);
                     pos_in[2] = in_word(req_vec_z);
                  end
                  MODE_VEL: begin
                     vel_in[0] = in_word(req_vec_x);
                     vel_in[1] = in_word(req_vec_y);
                     vel_in[2] = in_word(req_vec_z);
                  end
                  default: ;
               endcase
               if (req_mode == MODE_STEP && en_ff) begin
                  thr_in[0] = in_word(req_vec_x);
                  thr_in[1] = in_word(req_vec_y);
                  thr_in[2] = in_word(req_vec_z);
                  dt_in     = req_time_step;
                  sum_in    = '0;
                  ax_in     = '0;
                  state_in  = ST_SQUARE;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_SQUARE: begin
            if (mul_done) begin
               sum_in = sum_ff + mul_prod[2*W-1:0];
               if (ax_ff == AX_LAST) begin
                  ax_in    = '0;
                  state_in = ST_ROOT;
               end else begin
                  ax_in = ax_ff + 1'b1;
               end
            end
         end
         ST_ROOT: begin
            if (iter_done) begin
               spd_in   = iter_res;
               state_in = ST_DRAG_T;
            end
         end
         ST_DRAG_T: begin
            if (mul_done) begin
               tmp_in   = mul_res;
               state_in = ST_DRAG_S;
            end
         end
         ST_DRAG_S: begin
            if (mul_done) begin
               s_in     = mul_res;
               state_in = ST_WEIGHT;
            end
         end
         ST_WEIGHT: begin
            if (mul_done) begin
               wgt_in   = mul_res;
               state_in = ST_DT_SQ;
            end
         end
         ST_DT_SQ: begin
            if (mul_done) begin
               dt2_in   = mul_res;
               state_in = ST_FORCE;
            end
         end
         ST_FORCE: begin
            if (mul_done) begin
               frc_in[ax_ff] = sat_sub(f_force, mul_res);
               state_in      = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (iter_done) begin
               acc_in[ax_ff] = iter_res;
               if (ax_ff == AX_LAST) begin
                  ax_in    = '0;
                  state_in = ST_VEL_T;
               end else begin
                  ax_in    = ax_ff + 1'b1;
                  state_in = ST_FORCE;
               end
            end
         end
         ST_VEL_T: begin
            if (mul_done) begin
               // velocity term goes in negative on x and y
               tmp_in = (ax_ff == AX_LAST) ? sat_add(pos_ff[ax_ff], mul_res)
                                           : sat_sub(pos_ff[ax_ff], mul_res);
               state_in = ST_HALF;
            end
         end
         ST_HALF: begin
            if (mul_done) begin
               pos_in[ax_ff] = sat_add(tmp_ff, mul_res);
               state_in      = ST_VEL_D;
            end
         end
         ST_VEL_D: begin
            if (mul_done) begin
               vel_in[ax_ff] = sat_add(cur_vel, mul_res);
               if (ax_ff == AX_LAST) begin
                  ax_in    = '0;
                  state_in = ST_RESP;
               end else begin
                  ax_in    = ax_ff + 1'b1;
                  state_in = ST_VEL_T;
               end
            end
         end
         ST_RESP: begin
            if (rsp_free) begin
               for (int i = 0; i < 3; i++) begin
                  opos_in[i] = out_word(pos_ff[i]);
                  ovel_in[i] = out_word(vel_ff[i]);
                  oacc_in[i] = out_word(acc_ff[i]);
                  ofrc_in[i] = out_word(frc_ff[i]);
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      thr_ff  <= thr_in;
      dt_ff   <= dt_in;
      sum_ff  <= sum_in;
      spd_ff  <= spd_in;
      s_ff    <= s_in;
      wgt_ff  <= wgt_in;
      dt2_ff  <= dt2_in;
      tmp_ff  <= tmp_in;
      opos_ff <= opos_in;
      ovel_ff <= ovel_in;
      oacc_ff <= oacc_in;
      ofrc_ff <= ofrc_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         issued_ff    <= 1'b0;
         ax_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         en_ff        <= 1'b0;
         mass_ff      <= MASS_RESET;
         dcon_ff      <= '0;
         dmul_ff      <= DRAG_MUL_RESET;
         grav_ff      <= GRAVITY_RESET;
         for (int i = 0; i < 3; i++) begin
            pos_ff[i] <= '0;
            vel_ff[i] <= '0;
            acc_ff[i] <= '0;
            frc_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         ax_ff        <= ax_in;
         rsp_valid_ff <= rsp_valid_in;
         en_ff        <= en_in;
         mass_ff      <= mass_in;
         dcon_ff      <= dcon_in;
         dmul_ff      <= dmul_in;
         grav_ff      <= grav_in;
         pos_ff       <= pos_in;
         vel_ff       <= vel_in;
         acc_ff       <= acc_in;
         frc_ff       <= frc_in;
      end
   end

   pmdi_mul #(
      .WORD_BITS(W),
      .MUL_BITS (MW)
   ) u_mul (
      .clock(clock),
      .reset(reset),
      .ctl  (mul_ctl),
      .op_a (op_a),
      .op_b (op_b),
      .done (mul_done),
      .prod (mul_prod),
      .res  (mul_res)
   );

   pmdi_iter #(
      .WORD_BITS(W)
   ) u_iter (
      .clock  (clock),
      .reset  (reset),
      .ctl    (iter_ctl),
      .x_val  (iter_x),
      .divisor(div_d),
      .done   (iter_done),
      .res    (iter_res)
   );

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_pos_x = opos_ff[0];
   assign rsp_pos_y = opos_ff[1];
   assign rsp_pos_z = opos_ff[2];
   assign rsp_vel_x = ovel_ff[0];
   assign rsp_vel_y = ovel_ff[1];
   assign rsp_vel_z = ovel_ff[2];
   assign rsp_acc_x = oacc_ff[0];
   assign rsp_acc_y = oacc_ff[1];
   assign rsp_acc_z = oacc_ff[2];
   assign rsp_net_force_x = ofrc_ff[0];
   assign rsp_net_force_y = ofrc_ff[1];
   assign rsp_net_force_z = ofrc_ff[2];

   `PMDI_ASSERT(a_rsp_load, clock, reset, (state_ff == ST_RESP && rsp_free) |=> (state_ff == ST_IDLE && rsp_valid_ff))
   `PMDI_ASSERT_IMPLY(a_iter_owner, clock, reset, iter_done, state_ff == ST_ROOT || state_ff == ST_DIVIDE)
   `PMDI_ASSERT_IMPLY(a_mul_issued, clock, reset, mul_done, issued_ff && mul_state)

endmodule
